### design/wsc_pkg.sv
package wsc_pkg;

  localparam int unsigned NumChan   = 8;
  localparam int unsigned ChanW     = 3;
  localparam int unsigned WaveBytes = 128;
  localparam int unsigned PtrW      = 7;
  localparam int unsigned StepW     = 26;
  localparam int unsigned AccW      = 23;
  localparam int unsigned WorkW     = 28;
  localparam int unsigned PhaseW    = 23;
  localparam int unsigned LenW      = 6;
  localparam int unsigned LenShift  = 18;
  localparam int unsigned FreqW     = 18;
  localparam int unsigned SampleW   = 14;
  localparam int unsigned VolShift  = 6;
  localparam int unsigned ActW      = 4;
  localparam int unsigned SpdShift  = 20;

  localparam logic [StepW-1:0] StepReset = 26'd22696400;

  // Command codes carried on the request channel.
  localparam logic [1:0] CmdDataWr  = 2'd0;
  localparam logic [1:0] CmdAddrWr  = 2'd1;
  localparam logic [1:0] CmdDummyRd = 2'd2;
  localparam logic [1:0] CmdRender  = 2'd3;

  // Byte positions within a channel's eight-byte register block.
  localparam logic [2:0] RegFreqLo  = 3'd0;
  localparam logic [2:0] RegFreqMid = 3'd2;
  localparam logic [2:0] RegFreqHi  = 3'd4;
  localparam logic [2:0] RegOffset  = 3'd6;
  localparam logic [2:0] RegVolume  = 3'd7;

  // Wave length is held in units of 2^18 phase steps.
  localparam logic [LenW-1:0]    LenReset  = 6'h10;
  localparam logic [LenW-1:0]    LenTop    = 6'h20;
  localparam logic [ActW-1:0]    ActReset  = 4'd8;
  localparam logic [SampleW-1:0] SampleMax = 14'd14400;

  typedef struct packed {
    logic [FreqW-1:0]   freq;
    logic [LenW-1:0]    len;
    logic [PhaseW-1:0]  phase;
    logic [AccW-1:0]    accum;
    logic [7:0]         ofs;
    logic [3:0]         vol;
    logic               dirty;
    logic [SampleW-1:0] last;
  } chan_entry_t;

  localparam chan_entry_t ChanReset = '{
    freq:  '0,
    len:   LenReset,
    phase: '0,
    accum: '0,
    ofs:   '0,
    vol:   '0,
    dirty: 1'b0,
    last:  '0
  };

endpackage

### design/wsc_if.sv
interface wsc_cmd_if;
  import wsc_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data;
  logic [2:0] channel;

  modport source (output valid, output command, output data, output channel, input ready);
  modport sink   (input valid, input command, input data, input channel, output ready);
endinterface

interface wsc_smp_if;
  import wsc_pkg::*;

  logic               valid;
  logic               ready;
  logic [SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### design/wsc_ram.sv
module wsc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### design/wavetable_sound_channels.sv
// Eight-channel wavetable sound unit.
//
// Requests arrive on cmd_i (valid/ready): a data port write, an address port
// write, a dummy read, or a render of one channel. Only a render answers, with
// one sample on smp_o (valid/ready). The user writes the accumulator step via
// cfg_wr_en_i/cfg_wr_data_i while no request is in flight; the block won't check.
//
// Pointer and address writes, dummy reads and wave byte writes are done in S_IDLE
// alone; a write that lands on a channel register also passes S_CREAD, as the
// channel entry is read from the channel RAM, modified and written back. An
// inactive render passes S_STORE only; an active one passes S_RLOAD and S_STORE
// when its accumulator stays non-negative, adds S_WREAD and S_VOICE when the
// volume changed since its last sample, and k S_LOOP steps first on a wrap, k
// being the number of wrap-around steps: at most 64 (one active channel and the
// largest step), as the shared phase adder does one step per cycle. The sample
// is registered and appears in the cycle in which the next request can be taken.
//
// After reset the wave RAM reads as zero and every channel holds its default
// entry, through per-entry valid bits, so no clearing pass is needed. While the
// receiver stalls, a finished render holds in its final step until the output
// register is free, and no request is accepted in that time.
module wavetable_sound_channels (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wr_en_i,
  input  logic [wsc_pkg::StepW-1:0]  cfg_wr_data_i,
  wsc_cmd_if.sink                    cmd_i,
  wsc_smp_if.source                  smp_o
);
  import wsc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CREAD,
    S_RLOAD,
    S_LOOP,
    S_WREAD,
    S_VOICE,
    S_STORE
  } state_e;

  localparam int unsigned EntryW = $bits(chan_entry_t);

  state_e state_q;

  // Global registers.
  logic [StepW-1:0] step_q;
  logic [PtrW-1:0]  ptr_q;
  logic             auto_inc_q;
  logic [ActW-1:0]  active_q;
  logic [WaveBytes-1:0] wave_vld_q;
  logic [NumChan-1:0]   chan_vld_q;

  // Working registers of the request in flight.
  logic [ChanW-1:0]         ch_q;
  logic [7:0]               data_q;
  logic [2:0]               sel_q;
  logic                     skip_q;
  logic signed [WorkW-1:0]  acc_q;
  logic [PhaseW-1:0]        phase_q;
  logic [FreqW-1:0]         freq_q;
  logic [LenW-1:0]          len_q;
  logic [7:0]               ofs_q;
  logic [3:0]               vol_q;
  logic                     dirty_q;
  logic [SampleW-1:0]       last_q;
  logic                     nib_sel_q;
  logic                     wv_hit_q;

  // Output register.
  logic                     out_valid_q;
  logic [SampleW-1:0]       sample_q;

  logic in_acc;
  logic is_chan_reg;
  logic ch_active;
  logic store_go;

  logic                wave_we;
  logic                wave_re;
  logic [PtrW-1:0]     wave_raddr;
  logic [7:0]          wave_rdata;
  logic [7:0]          wave_idx;

  logic                chan_we;
  logic                chan_re;
  logic [ChanW-1:0]    chan_raddr;
  logic [EntryW-1:0]   chan_rdata;
  logic [EntryW-1:0]   chan_wdata;
  chan_entry_t         ent;
  chan_entry_t         reg_entry;
  chan_entry_t         store_entry;
  logic [LenW-1:0]     new_len;

  logic signed [WorkW-1:0] acc_ld;
  logic signed [WorkW-1:0] acc_nx;
  logic [PhaseW:0]         phase_sum;
  logic [PhaseW:0]         len_full;
  logic [PhaseW:0]         phase_wrap;
  logic [3:0]              nib;
  logic [7:0]              prod;
  logic [SampleW-1:0]      voice;

  assign cmd_i.ready  = (state_q == S_IDLE);
  assign in_acc       = cmd_i.valid && cmd_i.ready;
  assign smp_o.valid  = out_valid_q;
  assign smp_o.sample = sample_q;
  assign store_go     = !out_valid_q || smp_o.ready;

  // Pointer in the upper half lands on a channel register that holds state.
  assign is_chan_reg = ptr_q[PtrW-1] && (ptr_q[2:0] inside {RegFreqLo, RegFreqMid,
                                                             RegFreqHi, RegOffset, RegVolume});
  assign ch_active   = {1'b0, cmd_i.channel} >= (ActReset - active_q);

  // Wave RAM: one byte holds two samples, low nibble first.
  assign wave_we    = in_acc && (cmd_i.command == CmdDataWr);
  assign wave_re    = (state_q == S_WREAD);
  assign wave_idx   = ofs_q + {3'b000, phase_q[PhaseW-1:LenShift]};
  assign wave_raddr = wave_idx[7:1];

  wsc_ram #(
    .Width (8),
    .Depth (WaveBytes)
  ) u_wave_ram (
    .clk_i   (clk_i),
    .we_i    (wave_we),
    .waddr_i (ptr_q),
    .wdata_i (cmd_i.data),
    .re_i    (wave_re),
    .raddr_i (wave_raddr),
    .rdata_o (wave_rdata)
  );

  // Channel RAM: one entry per channel, read-modify-write per request.
  assign chan_re    = in_acc && (((cmd_i.command == CmdRender) && ch_active) ||
                                 ((cmd_i.command == CmdDataWr) && is_chan_reg));
  assign chan_raddr = (cmd_i.command == CmdRender) ? cmd_i.channel : ptr_q[5:3];
  assign chan_we    = (state_q == S_CREAD) || ((state_q == S_STORE) && store_go && !skip_q);
  assign chan_wdata = (state_q == S_CREAD) ? reg_entry : store_entry;

  wsc_ram #(
    .Width (EntryW),
    .Depth (NumChan)
  ) u_chan_ram (
    .clk_i   (clk_i),
    .we_i    (chan_we),
    .waddr_i (ch_q),
    .wdata_i (chan_wdata),
    .re_i    (chan_re),
    .raddr_i (chan_raddr),
    .rdata_o (chan_rdata)
  );

  // An entry never written reads as the reset entry.
  assign ent = chan_vld_q[ch_q] ? chan_entry_t'(chan_rdata) : ChanReset;

  // Register write decode on the fetched entry.
  always_comb begin
    reg_entry = ent;
    new_len   = LenTop - {1'b0, data_q[4:2], 2'b00};
    case (sel_q)
      RegFreqLo:  reg_entry.freq[7:0]  = data_q;
      RegFreqMid: reg_entry.freq[15:8] = data_q;
      RegFreqHi: begin
        reg_entry.freq[FreqW-1:16] = data_q[1:0];
        if (new_len != ent.len) begin
          reg_entry.len   = new_len;
          reg_entry.phase = '0;
        end
      end
      RegOffset:  reg_entry.ofs = data_q;
      RegVolume: begin
        reg_entry.vol   = data_q[3:0];
        reg_entry.dirty = 1'b1;
      end
      default: ;
    endcase
  end

  assign store_entry = '{
    freq:  freq_q,
    len:   len_q,
    phase: phase_q,
    accum: acc_q[AccW-1:0],
    ofs:   ofs_q,
    vol:   vol_q,
    dirty: dirty_q,
    last:  last_q
  };

  // Accumulator and phase step.
  assign acc_ld     = $signed({5'b0, ent.accum}) - $signed({2'b0, step_q});
  assign acc_nx     = acc_q + $signed({4'b0, active_q, {SpdShift{1'b0}}});
  assign phase_sum  = {1'b0, phase_q} + {{(PhaseW + 1 - FreqW){1'b0}}, freq_q};
  assign len_full   = {len_q, {LenShift{1'b0}}};
  assign phase_wrap = (phase_sum >= len_full) ? (phase_sum - len_full) : phase_sum;

  // Sample lookup scaled by volume.
  assign nib   = !wv_hit_q ? 4'd0 : (nib_sel_q ? wave_rdata[7:4] : wave_rdata[3:0]);
  assign prod  = nib * vol_q;
  assign voice = {prod, {VolShift{1'b0}}};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= StepReset;
      ptr_q       <= '0;
      auto_inc_q  <= 1'b1;
      active_q    <= ActReset;
      wave_vld_q  <= '0;
      chan_vld_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        step_q <= cfg_wr_data_i;
      end
      if (out_valid_q && smp_o.ready && !((state_q == S_STORE) && store_go)) begin
        out_valid_q <= 1'b0;
      end
      if (chan_we) begin
        chan_vld_q[ch_q] <= 1'b1;
      end

      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            data_q <= cmd_i.data;
            sel_q  <= ptr_q[2:0];
            case (cmd_i.command)
              CmdDataWr: begin
                wave_vld_q[ptr_q] <= 1'b1;
                ch_q              <= ptr_q[5:3];
                if (auto_inc_q) begin
                  ptr_q <= ptr_q + 1'b1;
                end
                if (is_chan_reg) begin
                  state_q <= S_CREAD;
                end
                // The last channel's volume byte also sets the channel count.
                if (ptr_q[PtrW-1] && (ptr_q[5:3] == ChanW'(NumChan - 1)) &&
                    (ptr_q[2:0] == RegVolume)) begin
                  active_q <= {1'b0, cmd_i.data[6:4]} + 1'b1;
                end
              end
              CmdAddrWr: begin
                ptr_q      <= cmd_i.data[PtrW-1:0];
                auto_inc_q <= cmd_i.data[7];
              end
              CmdDummyRd: begin
                if (auto_inc_q) begin
                  ptr_q <= ptr_q + 1'b1;
                end
              end
              CmdRender: begin
                ch_q <= cmd_i.channel;
                if (ch_active) begin
                  skip_q  <= 1'b0;
                  state_q <= S_RLOAD;
                end else begin
                  skip_q  <= 1'b1;
                  last_q  <= '0;
                  state_q <= S_STORE;
                end
              end
              default: ;
            endcase
          end
        end

        S_CREAD: begin
          state_q <= S_IDLE;
        end

        S_RLOAD: begin
          acc_q   <= acc_ld;
          phase_q <= ent.phase;
          freq_q  <= ent.freq;
          len_q   <= ent.len;
          ofs_q   <= ent.ofs;
          vol_q   <= ent.vol;
          last_q  <= ent.last;
          // The flag survives a wrap and is cleared by a recompute without one.
          dirty_q <= ent.dirty && acc_ld[WorkW-1];
          if (acc_ld[WorkW-1]) begin
            state_q <= S_LOOP;
          end else if (ent.dirty) begin
            // Volume changed since the last sample: recompute it.
            state_q <= S_WREAD;
          end else begin
            state_q <= S_STORE;
          end
        end

        S_LOOP: begin
          acc_q   <= acc_nx;
          phase_q <= phase_wrap[PhaseW-1:0];
          if (!acc_nx[WorkW-1]) begin
            state_q <= S_WREAD;
          end
        end

        S_WREAD: begin
          nib_sel_q <= wave_idx[0];
          wv_hit_q  <= wave_vld_q[wave_raddr];
          state_q   <= S_VOICE;
        end

        S_VOICE: begin
          last_q  <= voice;
          state_q <= S_STORE;
        end

        S_STORE: begin
          if (store_go) begin
            out_valid_q <= 1'b1;
            sample_q    <= last_q;
            state_q     <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A presented sample never exceeds full nibble times full volume.
  property p_sample_range;
    @(posedge clk_i) disable iff (!rst_ni)
      smp_o.valid |-> (smp_o.sample <= SampleMax);
  endproperty
  a_sample_range: assert property (p_sample_range)
    else $error("sample above full scale");

  // The wrap loop only runs while the accumulator is negative.
  property p_loop_negative;
    @(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_LOOP) |-> acc_q[WorkW-1];
  endproperty
  a_loop_negative: assert property (p_loop_negative)
    else $error("wrap step with non-negative accumulator");

  // A stored phase always lies inside the wave length.
  property p_phase_in_len;
    @(posedge clk_i) disable iff (!rst_ni)
      (chan_we && (state_q == S_STORE)) |-> ({1'b0, phase_q} < len_full);
  endproperty
  a_phase_in_len: assert property (p_phase_in_len)
    else $error("phase written back beyond wave length");

  // A render that produces a sample never leaves the output register
  // overwritten while it is still waiting.
  property p_no_overwrite;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && !smp_o.ready) |=> (out_valid_q && $stable(sample_q));
  endproperty
  a_no_overwrite: assert property (p_no_overwrite)
    else $error("waiting sample overwritten");

endmodule

### dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wsc_pkg::*;

  // Run shape. A render can spend up to 64 wrap steps plus its other states, so
  // a quiet spell of QuietCycles covers any request still in work.
  localparam int ScriptLen   = 28;
  localparam int NumPhases   = 7;
  localparam int PhaseItems  = 205;
  localparam int QuietCycles = 100;
  localparam int SqueezeLen  = 600;
  localparam int CycleLimit  = 1000000;

  localparam logic [7:0] LenMask = 8'h1C;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         byte_val;
    logic [2:0]         ch;
    bit                 pinned;
    logic [SampleW-1:0] level;
  } script_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_wr_en_i;
  logic [StepW-1:0]   cfg_wr_data_i;

  wsc_cmd_if req_if ();
  wsc_smp_if smp_if ();

  wavetable_sound_channels uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .cmd_i         (req_if),
    .smp_o         (smp_if)
  );

  // Shadow copy of the sound unit: wave RAM, pointer, and per-channel state.
  logic [3:0]         wave_nib [256];
  logic [PtrW-1:0]    ptr_q;
  logic               autoinc_q;
  logic [ActW-1:0]    active_q;
  logic [FreqW-1:0]   freq_q [NumChan];
  logic [23:0]        len_q [NumChan];
  logic [23:0]        phase_q [NumChan];
  longint             accum_q [NumChan];
  logic [7:0]         ofs_q [NumChan];
  logic [3:0]         vol_q [NumChan];
  logic               dirty_q [NumChan];
  logic [SampleW-1:0] held_q [NumChan];
  logic [StepW-1:0]   step_q;

  // Samples still owed by the block, oldest first.
  logic [SampleW-1:0] pending_samples [$];

  int  error_count;
  int  issued_count;
  int  cycle_count;
  int  send_gap_pct;
  int  stall_pct;
  bit  hold_rx;
  bit  squeeze_go;

  // The opening script. Rows with pinned set carry a sample that can be read
  // straight off the behaviour: silence after reset, the loudest possible
  // sample, and silence from a channel that is switched off. Every other
  // render is left to the shadow model.
  script_row_t opening_script [ScriptLen] = '{
    '{CmdRender,  8'h00, 3'd0, 1'b1, 14'd0},     // reset state, volume is zero
    '{CmdRender,  8'h00, 3'd7, 1'b1, 14'd0},
    '{CmdAddrWr,  8'hFF, 3'd0, 1'b0, 14'd0},     // pointer 0x7F, auto-increment
    '{CmdDataWr,  8'h7F, 3'd0, 1'b0, 14'd0},     // channel 7 volume 15, all active
    '{CmdDataWr,  8'hFF, 3'd0, 1'b0, 14'd0},     // pointer wrapped, wave 0/1 = 15
    '{CmdRender,  8'h00, 3'd7, 1'b1, SampleMax}, // full nibble times full volume
    '{CmdRender,  8'hFF, 3'd7, 1'b0, 14'd0},
    '{CmdDummyRd, 8'h00, 3'd0, 1'b0, 14'd0},
    '{CmdAddrWr,  8'h40, 3'd0, 1'b0, 14'd0},     // channel 0 block, no increment
    '{CmdDataWr,  8'hFF, 3'd0, 1'b0, 14'd0},
    '{CmdDummyRd, 8'h00, 3'd0, 1'b0, 14'd0},     // pointer must not move
    '{CmdDataWr,  8'h00, 3'd0, 1'b0, 14'd0},
    '{CmdAddrWr,  8'hF8, 3'd0, 1'b0, 14'd0},     // channel 7 block
    '{CmdDataWr,  8'hFF, 3'd0, 1'b0, 14'd0},     // frequency low
    '{CmdDataWr,  8'hA5, 3'd0, 1'b0, 14'd0},     // byte with no register
    '{CmdDataWr,  8'hFF, 3'd0, 1'b0, 14'd0},     // frequency middle
    '{CmdAddrWr,  8'hFC, 3'd0, 1'b0, 14'd0},
    '{CmdDataWr,  8'hFF, 3'd0, 1'b0, 14'd0},     // shortest wave, phase cleared
    '{CmdAddrWr,  8'hFE, 3'd0, 1'b0, 14'd0},
    '{CmdDataWr,  8'h80, 3'd0, 1'b0, 14'd0},     // wave offset
    '{CmdDataWr,  8'h0F, 3'd0, 1'b0, 14'd0},     // one active channel only
    '{CmdRender,  8'h00, 3'd0, 1'b1, 14'd0},     // switched off
    '{CmdRender,  8'h00, 3'd6, 1'b1, 14'd0},     // switched off
    '{CmdRender,  8'h00, 3'd7, 1'b0, 14'd0},
    '{CmdRender,  8'h00, 3'd7, 1'b0, 14'd0},
    '{CmdAddrWr,  8'hFC, 3'd0, 1'b0, 14'd0},
    '{CmdDataWr,  8'h00, 3'd0, 1'b0, 14'd0},     // longest wave
    '{CmdRender,  8'h00, 3'd7, 1'b0, 14'd0}
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic void clear_shadow();
    for (int i = 0; i < 256; i++) wave_nib[i] = '0;
    ptr_q     = '0;
    autoinc_q = 1'b1;
    active_q  = ActReset;
    step_q    = StepReset;
    for (int c = 0; c < NumChan; c++) begin
      freq_q[c]  = '0;
      len_q[c]   = 24'(LenReset) << LenShift;
      phase_q[c] = '0;
      accum_q[c] = 0;
      ofs_q[c]   = '0;
      vol_q[c]   = '0;
      dirty_q[c] = 1'b0;
      held_q[c]  = '0;
    end
  endfunction

  function automatic void advance_pointer();
    if (autoinc_q) ptr_q = ptr_q + 1'b1;
  endfunction

  // Current wave nibble under the channel's phase, scaled by its volume.
  function automatic logic [SampleW-1:0] voice_level(input logic [2:0] c);
    logic [7:0] idx;
    int         prod;
    idx  = 8'(phase_q[c] >> LenShift) + ofs_q[c];
    prod = (int'(wave_nib[idx]) * int'(vol_q[c])) << VolShift;
    return SampleW'(prod);
  endfunction

  function automatic void port_write(input logic [7:0] d);
    logic [2:0]      c;
    logic [LenW-1:0] units;
    logic [23:0]     new_len;
    wave_nib[{ptr_q, 1'b0}] = d[3:0];
    wave_nib[{ptr_q, 1'b1}] = d[7:4];
    c = ptr_q[5:3];
    // The upper half of the RAM doubles as the channel register file.
    if (ptr_q[6]) begin
      case (ptr_q[2:0])
        RegFreqLo:  freq_q[c][7:0]  = d;
        RegFreqMid: freq_q[c][15:8] = d;
        RegFreqHi: begin
          freq_q[c][17:16] = d[1:0];
          units   = LenTop - LenW'(d & LenMask);
          new_len = 24'(units) << LenShift;
          if (len_q[c] != new_len) begin
            len_q[c]   = new_len;
            phase_q[c] = '0;
          end
        end
        RegOffset: ofs_q[c] = d;
        RegVolume: begin
          vol_q[c]   = d[3:0];
          dirty_q[c] = 1'b1;
          if (c == 3'(NumChan - 1)) active_q = ActW'(d[6:4]) + 1'b1;
        end
        default: ;
      endcase
    end
    advance_pointer();
  endfunction

  function automatic logic [SampleW-1:0] render_voice(input logic [2:0] c);
    longint acc;
    longint spd;
    longint laps;
    longint ph;
    acc = accum_q[c] - longint'(step_q);
    if (acc >= 0) begin
      // No new output period yet: only a volume change refreshes the sample.
      if (dirty_q[c]) begin
        held_q[c]  = voice_level(c);
        dirty_q[c] = 1'b0;
      end
      accum_q[c] = acc;
      return held_q[c];
    end
    spd = longint'(active_q) << SpdShift;
    if (spd <= 0) spd = longint'(1) << SpdShift;
    laps = (spd - 1 - acc) / spd;
    acc  = acc + laps * spd;
    ph   = longint'(phase_q[c]) + laps * longint'(freq_q[c]);
    if (len_q[c] != '0) ph = ph % longint'(len_q[c]);
    phase_q[c] = ph[23:0];
    accum_q[c] = acc;
    held_q[c]  = voice_level(c);
    return held_q[c];
  endfunction

  // Applies one accepted request to the shadow state and reports the sample
  // that it should produce, if any.
  function automatic void wave_unit_step(input logic [1:0] op, input logic [7:0] d,
                                         input logic [2:0] ch, output bit answers,
                                         output logic [SampleW-1:0] level);
    answers = 1'b0;
    level   = '0;
    case (op)
      CmdDataWr:  port_write(d);
      CmdAddrWr: begin
        ptr_q     = d[6:0];
        autoinc_q = d[7];
      end
      CmdDummyRd: advance_pointer();
      default: begin
        answers = 1'b1;
        if (int'(ch) >= int'(NumChan) - int'(active_q)) level = render_voice(ch);
      end
    endcase
  endfunction

  // Offers one request, optionally after an idle spell, and records what it
  // owes once the block has taken it.
  task automatic issue_request(input logic [1:0] op, input logic [7:0] d,
                               input logic [2:0] ch, input bit pinned,
                               input logic [SampleW-1:0] pinned_level);
    bit                 answers;
    logic [SampleW-1:0] level;
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_gap_pct);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= op;
    req_if.data    <= d;
    req_if.channel <= ch;
    do @(posedge clk_i); while (!req_if.ready);
    wave_unit_step(op, d, ch, answers, level);
    if (answers) pending_samples.push_back(pinned ? pinned_level : level);
    issued_count++;
  endtask

  task automatic issue_plain(input logic [1:0] op, input logic [7:0] d,
                             input logic [2:0] ch);
    issue_request(op, d, ch, 1'b0, '0);
  endtask

  // Most bursts are well-formed: wave fills, whole channel blocks and runs of
  // renders on live channels. The rest is loose noise.
  task automatic random_burst();
    int         kind;
    int         n;
    logic [2:0] c;
    logic [7:0] d;
    kind = $urandom_range(9);
    case (kind)
      0, 1: begin
        issue_plain(CmdAddrWr, {1'b1, 7'($urandom_range(127))}, 3'($urandom));
        n = $urandom_range(8, 1);
        repeat (n) issue_plain(CmdDataWr, 8'($urandom), 3'($urandom));
      end
      2, 3: begin
        c = 3'($urandom);
        issue_plain(CmdAddrWr, {2'b11, c, 3'd0}, 3'($urandom));
        for (int b = 0; b < 8; b++) begin
          d = 8'($urandom);
          // Keep all eight channels live most of the time.
          if (b == int'(RegVolume) && c == 3'(NumChan - 1) && $urandom_range(9) < 7)
            d[6:4] = 3'd7;
          issue_plain(CmdDataWr, d, 3'($urandom));
        end
      end
      4, 5, 6, 7: begin
        n = $urandom_range(8, 2);
        repeat (n) begin
          if ($urandom_range(9) < 8)
            c = 3'($urandom_range(NumChan - 1, int'(NumChan) - int'(active_q)));
          else
            c = 3'($urandom);
          issue_plain(CmdRender, 8'($urandom), c);
        end
      end
      8: issue_plain(2'($urandom), 8'($urandom), 3'($urandom));
      default: begin
        issue_plain(CmdAddrWr, 8'($urandom), 3'($urandom));
        n = $urandom_range(3, 1);
        repeat (n) issue_plain(CmdDummyRd, 8'($urandom), 3'($urandom));
      end
    endcase
  endtask

  // Stops offering requests, waits for every owed sample, then lets the
  // block finish any register write still in progress.
  task automatic settle_block();
    req_if.valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  task automatic load_step(input logic [StepW-1:0] v);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= v;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
    step_q = v;
  endtask

  // Sample side back-pressure.
  always @(posedge clk_i) begin
    smp_if.ready <= !hold_rx && ($urandom_range(99) >= stall_pct);
  end

  // A long hold-off on the sample side, counted here, while requests keep
  // coming so that the block fills up and refuses further requests.
  initial begin
    wait (squeeze_go);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (SqueezeLen) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  always @(posedge clk_i) begin : sample_check
    logic [SampleW-1:0] want;
    if (rst_ni && smp_if.valid && smp_if.ready) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample, expected none, got %0d", $time, smp_if.sample);
        error_count++;
      end else begin
        want = pending_samples.pop_front();
        if (smp_if.sample !== want) begin
          $display("%0t: sample mismatch, expected %0d, got %0d",
                   $time, want, smp_if.sample);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : main_flow
    logic [StepW-1:0] next_step;
    int               phase_start;
    error_count    = 0;
    issued_count   = 0;
    cycle_count    = 0;
    send_gap_pct   = 0;
    stall_pct      = 0;
    hold_rx        = 1'b0;
    squeeze_go     = 1'b0;
    cfg_wr_en_i    = 1'b0;
    cfg_wr_data_i  = '0;
    req_if.valid   = 1'b0;
    req_if.command = CmdDummyRd;
    req_if.data    = '0;
    req_if.channel = '0;
    smp_if.ready   = 1'b0;
    clear_shadow();

    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < ScriptLen; r++)
      issue_request(opening_script[r].op, opening_script[r].byte_val,
                    opening_script[r].ch, opening_script[r].pinned,
                    opening_script[r].level);

    // Each phase has its own step and its own idling pattern. The step runs
    // from zero, which never lets the accumulator fall, up to the largest
    // value, which gives the longest wrap loops.
    for (int p = 0; p < NumPhases; p++) begin
      settle_block();
      case (p)
        0: begin next_step = StepReset;     send_gap_pct = 0;  stall_pct = 0;  end
        1: begin next_step = '1;            send_gap_pct = 83; stall_pct = 0;  end
        2: begin next_step = StepW'(1);     send_gap_pct = 0;  stall_pct = 83; end
        3: begin
          next_step = StepW'($urandom_range(32'h3FFFFFF, 1));
          send_gap_pct = 7;
          stall_pct = 7;
        end
        4: begin
          next_step = StepW'($urandom_range(32'h7FFFFF, 1));
          send_gap_pct = 0;
          stall_pct = 0;
          squeeze_go = 1'b1;
        end
        5: begin
          next_step = StepW'($urandom_range(32'h1FFFFFF, 32'h100000));
          send_gap_pct = 7;
          stall_pct = 7;
        end
        default: begin next_step = '0; send_gap_pct = 0; stall_pct = 0; end
      endcase
      load_step(next_step);
      phase_start = issued_count;
      while (issued_count - phase_start < PhaseItems) random_burst();
    end

    settle_block();
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
